// ===== design/fgr_pkg.sv =====
// Shared types, constants and the run-code tables of the fax run-length decoder.
`timescale 1ns / 1ps
`default_nettype none

package fgr_pkg;

  // Result kinds reported on the output channel.
  localparam logic [1:0] KIND_BLACK_RUN = 2'd0;
  localparam logic [1:0] KIND_ROW_END   = 2'd1;
  localparam logic [1:0] KIND_INVALID   = 2'd2;
  localparam logic [1:0] KIND_PAGE_END  = 2'd3;

  // Configuration register indexes.
  localparam logic REG_LSB_FIRST = 1'b0;
  localparam logic REG_EOL_LIMIT = 1'b1;

  localparam int MAX_CODE  = 13;
  localparam int NUM_CODES = 91;

  // One run code: length, pattern right aligned, and run length in pixels.
  typedef struct packed {
    logic [3:0]  len;
    logic [12:0] val;
    logic [10:0] pels;
  } code_entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;
    logic       step;
    logic       flush;
    logic [2:0] bit_idx;
  } fgr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pend_valid;
    logic out_busy;
  } fgr_status_t;

  // One result item.
  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] row_number;
    logic [10:0] start_column;
    logic [10:0] run_length;
    logic [10:0] widest_column;
  } fgr_result_t;

  // Outcome of matching the gathered bits against one color's codes.
  typedef struct packed {
    logic        exact;
    logic        alive;
    logic        eol;
    logic [10:0] pels;
  } lookup_t;

  localparam code_entry_t WHITE_CODES [NUM_CODES] = '{
    '{4'd8, 13'b00110101, 11'd0},  '{4'd6, 13'b000111, 11'd1},
    '{4'd4, 13'b0111, 11'd2},      '{4'd4, 13'b1000, 11'd3},
    '{4'd4, 13'b1011, 11'd4},      '{4'd4, 13'b1100, 11'd5},
    '{4'd4, 13'b1110, 11'd6},      '{4'd4, 13'b1111, 11'd7},
    '{4'd5, 13'b10011, 11'd8},     '{4'd5, 13'b10100, 11'd9},
    '{4'd5, 13'b00111, 11'd10},    '{4'd5, 13'b01000, 11'd11},
    '{4'd6, 13'b001000, 11'd12},   '{4'd6, 13'b000011, 11'd13},
    '{4'd6, 13'b110100, 11'd14},   '{4'd6, 13'b110101, 11'd15},
    '{4'd6, 13'b101010, 11'd16},   '{4'd6, 13'b101011, 11'd17},
    '{4'd7, 13'b0100111, 11'd18},  '{4'd7, 13'b0001100, 11'd19},
    '{4'd7, 13'b0001000, 11'd20},  '{4'd7, 13'b0010111, 11'd21},
    '{4'd7, 13'b0000011, 11'd22},  '{4'd7, 13'b0000100, 11'd23},
    '{4'd7, 13'b0101000, 11'd24},  '{4'd7, 13'b0101011, 11'd25},
    '{4'd7, 13'b0010011, 11'd26},  '{4'd7, 13'b0100100, 11'd27},
    '{4'd7, 13'b0011000, 11'd28},  '{4'd8, 13'b00000010, 11'd29},
    '{4'd8, 13'b00000011, 11'd30}, '{4'd8, 13'b00011010, 11'd31},
    '{4'd8, 13'b00011011, 11'd32}, '{4'd8, 13'b00010010, 11'd33},
    '{4'd8, 13'b00010011, 11'd34}, '{4'd8, 13'b00010100, 11'd35},
    '{4'd8, 13'b00010101, 11'd36}, '{4'd8, 13'b00010110, 11'd37},
    '{4'd8, 13'b00010111, 11'd38}, '{4'd8, 13'b00101000, 11'd39},
    '{4'd8, 13'b00101001, 11'd40}, '{4'd8, 13'b00101010, 11'd41},
    '{4'd8, 13'b00101011, 11'd42}, '{4'd8, 13'b00101100, 11'd43},
    '{4'd8, 13'b00101101, 11'd44}, '{4'd8, 13'b00000100, 11'd45},
    '{4'd8, 13'b00000101, 11'd46}, '{4'd8, 13'b00001010, 11'd47},
    '{4'd8, 13'b00001011, 11'd48}, '{4'd8, 13'b01010010, 11'd49},
    '{4'd8, 13'b01010011, 11'd50}, '{4'd8, 13'b01010100, 11'd51},
    '{4'd8, 13'b01010101, 11'd52}, '{4'd8, 13'b00100100, 11'd53},
    '{4'd8, 13'b00100101, 11'd54}, '{4'd8, 13'b01011000, 11'd55},
    '{4'd8, 13'b01011001, 11'd56}, '{4'd8, 13'b01011010, 11'd57},
    '{4'd8, 13'b01011011, 11'd58}, '{4'd8, 13'b01001010, 11'd59},
    '{4'd8, 13'b01001011, 11'd60}, '{4'd8, 13'b00110010, 11'd61},
    '{4'd8, 13'b00110011, 11'd62}, '{4'd8, 13'b00110100, 11'd63},
    '{4'd5, 13'b11011, 11'd64},    '{4'd5, 13'b10010, 11'd128},
    '{4'd6, 13'b010111, 11'd192},  '{4'd7, 13'b0110111, 11'd256},
    '{4'd8, 13'b00110110, 11'd320}, '{4'd8, 13'b00110111, 11'd384},
    '{4'd8, 13'b01100100, 11'd448}, '{4'd8, 13'b01100101, 11'd512},
    '{4'd8, 13'b01101000, 11'd576}, '{4'd8, 13'b01100111, 11'd640},
    '{4'd9, 13'b011001100, 11'd704}, '{4'd9, 13'b011001101, 11'd768},
    '{4'd9, 13'b011010010, 11'd832}, '{4'd9, 13'b011010011, 11'd896},
    '{4'd9, 13'b011010100, 11'd960}, '{4'd9, 13'b011010101, 11'd1024},
    '{4'd9, 13'b011010110, 11'd1088}, '{4'd9, 13'b011010111, 11'd1152},
    '{4'd9, 13'b011011000, 11'd1216}, '{4'd9, 13'b011011001, 11'd1280},
    '{4'd9, 13'b011011010, 11'd1344}, '{4'd9, 13'b011011011, 11'd1408},
    '{4'd9, 13'b010011000, 11'd1472}, '{4'd9, 13'b010011001, 11'd1536},
    '{4'd9, 13'b010011010, 11'd1600}, '{4'd6, 13'b011000, 11'd1664},
    '{4'd9, 13'b010011011, 11'd1728}
  };

  localparam code_entry_t BLACK_CODES [NUM_CODES] = '{
    '{4'd10, 13'b0000110111, 11'd0}, '{4'd3, 13'b010, 11'd1},
    '{4'd2, 13'b11, 11'd2},          '{4'd2, 13'b10, 11'd3},
    '{4'd3, 13'b011, 11'd4},         '{4'd4, 13'b0011, 11'd5},
    '{4'd4, 13'b0010, 11'd6},        '{4'd5, 13'b00011, 11'd7},
    '{4'd6, 13'b000101, 11'd8},      '{4'd6, 13'b000100, 11'd9},
    '{4'd7, 13'b0000100, 11'd10},    '{4'd7, 13'b0000101, 11'd11},
    '{4'd7, 13'b0000111, 11'd12},    '{4'd8, 13'b00000100, 11'd13},
    '{4'd8, 13'b00000111, 11'd14},   '{4'd9, 13'b000011000, 11'd15},
    '{4'd10, 13'b0000010111, 11'd16}, '{4'd10, 13'b0000011000, 11'd17},
    '{4'd10, 13'b0000001000, 11'd18}, '{4'd11, 13'b00001100111, 11'd19},
    '{4'd11, 13'b00001101000, 11'd20}, '{4'd11, 13'b00001101100, 11'd21},
    '{4'd11, 13'b00000110111, 11'd22}, '{4'd11, 13'b00000101000, 11'd23},
    '{4'd11, 13'b00000010111, 11'd24}, '{4'd11, 13'b00000011000, 11'd25},
    '{4'd12, 13'b000011001010, 11'd26}, '{4'd12, 13'b000011001011, 11'd27},
    '{4'd12, 13'b000011001100, 11'd28}, '{4'd12, 13'b000011001101, 11'd29},
    '{4'd12, 13'b000001101000, 11'd30}, '{4'd12, 13'b000001101001, 11'd31},
    '{4'd12, 13'b000001101010, 11'd32}, '{4'd12, 13'b000001101011, 11'd33},
    '{4'd12, 13'b000011010010, 11'd34}, '{4'd12, 13'b000011010011, 11'd35},
    '{4'd12, 13'b000011010100, 11'd36}, '{4'd12, 13'b000011010101, 11'd37},
    '{4'd12, 13'b000011010110, 11'd38}, '{4'd12, 13'b000011010111, 11'd39},
    '{4'd12, 13'b000001101100, 11'd40}, '{4'd12, 13'b000001101101, 11'd41},
    '{4'd12, 13'b000011011010, 11'd42}, '{4'd12, 13'b000011011011, 11'd43},
    '{4'd12, 13'b000001010100, 11'd44}, '{4'd12, 13'b000001010101, 11'd45},
    '{4'd12, 13'b000001010110, 11'd46}, '{4'd12, 13'b000001010111, 11'd47},
    '{4'd12, 13'b000001100100, 11'd48}, '{4'd12, 13'b000001100101, 11'd49},
    '{4'd12, 13'b000001010010, 11'd50}, '{4'd12, 13'b000001010011, 11'd51},
    '{4'd12, 13'b000000100100, 11'd52}, '{4'd12, 13'b000000110111, 11'd53},
    '{4'd12, 13'b000000111000, 11'd54}, '{4'd12, 13'b000000100111, 11'd55},
    '{4'd12, 13'b000000101000, 11'd56}, '{4'd12, 13'b000001011000, 11'd57},
    '{4'd12, 13'b000001011001, 11'd58}, '{4'd12, 13'b000000101011, 11'd59},
    '{4'd12, 13'b000000101100, 11'd60}, '{4'd12, 13'b000001011010, 11'd61},
    '{4'd12, 13'b000001100110, 11'd62}, '{4'd12, 13'b000001100111, 11'd63},
    '{4'd10, 13'b0000001111, 11'd64}, '{4'd12, 13'b000011001000, 11'd128},
    '{4'd12, 13'b000011001001, 11'd192}, '{4'd12, 13'b000001011011, 11'd256},
    '{4'd12, 13'b000000110011, 11'd320}, '{4'd12, 13'b000000110100, 11'd384},
    '{4'd12, 13'b000000110101, 11'd448}, '{4'd13, 13'b0000001101100, 11'd512},
    '{4'd13, 13'b0000001101101, 11'd576}, '{4'd13, 13'b0000001001010, 11'd640},
    '{4'd13, 13'b0000001001011, 11'd704}, '{4'd13, 13'b0000001001100, 11'd768},
    '{4'd13, 13'b0000001001101, 11'd832}, '{4'd13, 13'b0000001110010, 11'd896},
    '{4'd13, 13'b0000001110011, 11'd960}, '{4'd13, 13'b0000001110100, 11'd1024},
    '{4'd13, 13'b0000001110101, 11'd1088}, '{4'd13, 13'b0000001110110, 11'd1152},
    '{4'd13, 13'b0000001110111, 11'd1216}, '{4'd13, 13'b0000001010010, 11'd1280},
    '{4'd13, 13'b0000001010011, 11'd1344}, '{4'd13, 13'b0000001010100, 11'd1408},
    '{4'd13, 13'b0000001010101, 11'd1472}, '{4'd13, 13'b0000001011010, 11'd1536},
    '{4'd13, 13'b0000001011011, 11'd1600}, '{4'd13, 13'b0000001100100, 11'd1664},
    '{4'd13, 13'b0000001100101, 11'd1728}
  };

  // Match right-aligned gathered bits of the given length against one color's codes.
  // The all-zero end-of-line code is common to both colors and handled apart.
  function automatic lookup_t code_lookup(input logic black, input logic [12:0] bits,
                                          input logic [3:0] len);
    lookup_t     r;
    code_entry_t e;
    logic [12:0] cur_l;
    logic [12:0] pat_l;
    logic [12:0] mask;
    r     = '0;
    cur_l = 13'(bits << (4'd13 - len));
    mask  = ~(13'h1fff >> len);
    for (int k = 0; k < NUM_CODES; k++) begin
      e     = black ? BLACK_CODES[k] : WHITE_CODES[k];
      pat_l = 13'(e.val << (4'd13 - e.len));
      if ((e.len >= len) && (((pat_l ^ cur_l) & mask) == 13'd0)) begin
        if (e.len == len) begin
          r.exact = 1'b1;
          r.pels  = e.pels;
        end else begin
          r.alive = 1'b1;
        end
      end
    end
    if (bits == 13'd0) begin
      if (len == 4'd8) begin
        r.eol   = 1'b1;
        r.exact = 1'b1;
      end else if (len < 4'd8) begin
        r.alive = 1'b1;
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/fgr_ctrl.sv =====
// Controller state machine: sequences the eight bits of each item and the final flush.
`timescale 1ns / 1ps
`default_nettype none

module fgr_ctrl
  import fgr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire fgr_status_t status,
  output fgr_cmd_t         cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t     state, state_next;
  logic [2:0] bit_idx, bit_idx_next;
  logic       can_step;

  // A bit may run unless a held result and a full output stage would collide.
  assign can_step = !(status.pend_valid && status.out_busy);
  assign in_ready = (state == S_IDLE);

  // Next state and commands.
  always_comb begin
    state_next   = state;
    bit_idx_next = bit_idx;
    cmd          = '0;
    cmd.bit_idx  = bit_idx;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load     = 1'b1;
          bit_idx_next = 3'd0;
          state_next   = S_RUN;
        end
      end
      S_RUN: begin
        if (can_step) begin
          cmd.step     = 1'b1;
          bit_idx_next = bit_idx + 3'd1;
          if (bit_idx == 3'd7) begin
            state_next = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (!status.pend_valid) begin
          state_next = S_IDLE;
        end else if (!status.out_busy) begin
          cmd.flush  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      bit_idx <= 3'd0;
    end else begin
      state   <= state_next;
      bit_idx <= bit_idx_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/fgr_dpath.sv =====
// Datapath: code matching, line position, empty-line count, result hold and output stage.
`timescale 1ns / 1ps
`default_nettype none

module fgr_dpath
  import fgr_pkg::*;
#(
  parameter int LINE_PIXELS = 1728
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire fgr_cmd_t    cmd,
  output fgr_status_t      status,
  input  wire logic [7:0]  code_byte,
  input  wire logic        wr_en,
  input  wire logic        wr_index,
  input  wire logic [3:0]  wr_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output fgr_result_t      out_res
);

  localparam int CW = $clog2(LINE_PIXELS + 1);
  localparam int RW = (CW > 11) ? CW : 11;

  localparam logic [1:0] MODE_DECODE = 2'd0;
  localparam logic [1:0] MODE_ZEROS  = 2'd1;
  localparam logic [1:0] MODE_ONE    = 2'd2;

  // Configuration.
  logic        lsb_first;
  logic [3:0]  eol_limit;

  // Decoder state.
  logic [7:0]  byte_q;
  logic [12:0] code_bits, code_bits_next;
  logic [3:0]  code_length, code_length_next;
  logic        is_black, is_black_next;
  logic [CW-1:0] column, column_next;
  logic [CW-1:0] widest, widest_next;
  logic [15:0] row_count, row_count_next;
  logic [3:0]  empty_eol_count, empty_eol_count_next;
  logic [15:0] last_empty_row, last_empty_row_next;
  logic [1:0]  resync_mode, resync_mode_next;
  logic [3:0]  zero_run, zero_run_next;

  // Result hold and output stage.
  logic        pend_valid;
  fgr_result_t pend_res;
  logic        emit;
  fgr_result_t emit_res;

  logic        bit_v;
  logic [12:0] nb;
  logic [3:0]  nl;
  lookup_t     lk;
  logic [3:0]  limit;
  logic [RW-1:0] room, pels_x, run_n, col_x, wid_x;
  logic [3:0]  zr_inc;

  assign status.pend_valid = pend_valid;
  assign status.out_busy   = out_valid && !out_ready;

  assign limit = (eol_limit == 4'd0) ? 4'd1 : eol_limit;
  assign bit_v = lsb_first ? byte_q[cmd.bit_idx] : byte_q[3'd7 - cmd.bit_idx];
  assign nb    = {code_bits[11:0], bit_v};
  assign nl    = code_length + 4'd1;
  assign lk    = code_lookup(is_black, nb, nl);

  // Run clamping to the line end.
  assign col_x  = RW'(column);
  assign room   = RW'(LINE_PIXELS) - col_x;
  assign pels_x = RW'(lk.pels);
  assign run_n  = (pels_x > room) ? room : pels_x;
  assign zr_inc = (zero_run < 4'd15) ? zero_run + 4'd1 : 4'd15;

  // One bit of decoding.
  always_comb begin
    code_bits_next       = code_bits;
    code_length_next     = code_length;
    is_black_next        = is_black;
    column_next          = column;
    widest_next          = widest;
    row_count_next       = row_count;
    empty_eol_count_next = empty_eol_count;
    last_empty_row_next  = last_empty_row;
    resync_mode_next     = resync_mode;
    zero_run_next        = zero_run;
    wid_x                = RW'(widest);
    emit                 = 1'b0;
    emit_res             = '0;
    emit_res.row_number  = row_count;
    if (cmd.step && (empty_eol_count < limit)) begin
      if (resync_mode == MODE_ZEROS) begin
        if (bit_v) begin
          zero_run_next = 4'd0;
        end else if (zr_inc >= 4'd6) begin
          zero_run_next    = 4'd0;
          resync_mode_next = MODE_ONE;
        end else begin
          zero_run_next = zr_inc;
        end
      end else if (resync_mode == MODE_ONE) begin
        // A one ends the line.
        if (bit_v) begin
          resync_mode_next = MODE_DECODE;
          is_black_next    = 1'b0;
          if (column == '0) begin
            if (last_empty_row != row_count) begin
              last_empty_row_next  = row_count;
              empty_eol_count_next = (empty_eol_count < 4'd15) ?
                                     empty_eol_count + 4'd1 : empty_eol_count;
              if (empty_eol_count_next >= limit) begin
                emit          = 1'b1;
                emit_res.kind = KIND_PAGE_END;
              end
            end
          end else begin
            if (column > widest) begin
              widest_next = column;
              wid_x       = col_x;
            end
            emit                 = 1'b1;
            emit_res.kind        = KIND_ROW_END;
            row_count_next       = (row_count != 16'hffff) ? row_count + 16'd1 : row_count;
            column_next          = '0;
            empty_eol_count_next = 4'd0;
          end
        end
      end else begin
        code_bits_next   = nb;
        code_length_next = nl;
        if (lk.exact || !lk.alive || (nl == 4'(MAX_CODE))) begin
          code_bits_next   = 13'd0;
          code_length_next = 4'd0;
          if (lk.exact && lk.eol) begin
            resync_mode_next = MODE_ONE;
          end else if (lk.exact) begin
            if (is_black && (run_n != '0)) begin
              emit                  = 1'b1;
              emit_res.kind         = KIND_BLACK_RUN;
              emit_res.start_column = col_x[10:0];
              emit_res.run_length   = run_n[10:0];
            end
            column_next = CW'(col_x + run_n);
            if (run_n < RW'(64)) begin
              is_black_next = !is_black;
            end
          end else begin
            emit             = 1'b1;
            emit_res.kind    = KIND_INVALID;
            resync_mode_next = MODE_ZEROS;
            zero_run_next    = bit_v ? 4'd0 : 4'd1;
          end
        end
      end
    end
    emit_res.widest_column = wid_x[10:0];
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      lsb_first       <= 1'b0;
      eol_limit       <= 4'd10;
      code_bits       <= 13'd0;
      code_length     <= 4'd0;
      is_black        <= 1'b0;
      column          <= '0;
      widest          <= '0;
      row_count       <= 16'd0;
      empty_eol_count <= 4'd0;
      last_empty_row  <= 16'd0;
      resync_mode     <= MODE_DECODE;
      zero_run        <= 4'd0;
      pend_valid      <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (wr_en) begin
        if (wr_index == REG_LSB_FIRST) begin
          lsb_first <= wr_data[0];
        end else begin
          eol_limit <= wr_data;
        end
      end
      code_bits       <= code_bits_next;
      code_length     <= code_length_next;
      is_black        <= is_black_next;
      column          <= column_next;
      widest          <= widest_next;
      row_count       <= row_count_next;
      empty_eol_count <= empty_eol_count_next;
      last_empty_row  <= last_empty_row_next;
      resync_mode     <= resync_mode_next;
      zero_run        <= zero_run_next;
      if (cmd.flush || (emit && pend_valid)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.flush) begin
        pend_valid <= 1'b0;
      end else if (emit) begin
        pend_valid <= 1'b1;
      end
    end
  end

  // Payload registers: input byte, held result and output stage.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      byte_q <= code_byte;
    end
    if (emit) begin
      pend_res <= emit_res;
    end
    if (cmd.flush || (emit && pend_valid)) begin
      out_res <= pend_res;
    end
  end

endmodule

`default_nettype wire

// ===== design/fax_g3_run_length_decoder.sv =====
// Top level of the one-dimensional G3 fax run-length decoder.
//
// Usage: raw coded bytes enter on the code_byte channel (in_valid/in_ready).
// Each byte is split into eight bits, taken in the order lsb_first selects,
// and matched one per cycle, unless stalled, against white or black run codes.
// Results leave on the output channel (out_valid/out_ready): black runs,
// row ends, invalid codes and page end; last marks the final result of a byte.
// A new byte is not taken before the last one is through: the accepting
// cycle loads it, the eight bits then run through the shared code matcher,
// and the done state flushes the held result, if any, before in_ready rises.
// The result of a bit is held until the next result or the flush, so the last
// flag is known; a stalled receiver holds the output stage, and no bit runs
// while a result is held and the output stage is full, so the byte takes
// longer by the stall. Registers are to be written only while the block idles,
// through wr_en/wr_index/wr_data; the block itself does not enforce this.
// Synchronous reset returns the decoder to white at row zero, column zero,
// drops any held result and sets lsb_first to 0 and eol_limit to 10.
// After page end every bit is ignored until reset or a larger eol_limit.
`timescale 1ns / 1ps
`default_nettype none

module fax_g3_run_length_decoder
  import fgr_pkg::*;
#(
  parameter int LINE_PIXELS = 1728
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  code_byte,
  input  wire logic        wr_en,
  input  wire logic        wr_index,
  input  wire logic [3:0]  wr_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       kind,
  output logic [15:0]      row_number,
  output logic [10:0]      start_column,
  output logic [10:0]      run_length,
  output logic [10:0]      widest_column,
  output logic             last
);

  fgr_cmd_t    cmd;
  fgr_status_t status;
  fgr_result_t res;
  logic        out_last;

  fgr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  fgr_dpath #(
    .LINE_PIXELS (LINE_PIXELS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .code_byte (code_byte),
    .wr_en     (wr_en),
    .wr_index  (wr_index),
    .wr_data   (wr_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (res)
  );

  // The last flag rides with the output stage: set when loaded by a flush.
  always_ff @(posedge clk) begin
    if (cmd.flush) begin
      out_last <= 1'b1;
    end else if (cmd.step && status.pend_valid) begin
      out_last <= 1'b0;
    end
  end

  assign kind          = res.kind;
  assign row_number    = res.row_number;
  assign start_column  = res.start_column;
  assign run_length    = res.run_length;
  assign widest_column = res.widest_column;
  assign last          = out_last;

endmodule

`default_nettype wire

// ===== design/fgr_checker.sv =====
// Port-level checker for the fax run-length decoder and its bind statement.
`timescale 1ns / 1ps
`default_nettype none

module fgr_checker
  import fgr_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  kind,
  input wire logic [10:0] start_column,
  input wire logic [10:0] run_length,
  input wire logic        last
);

  // A stalled result holds its kind and last flag.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(last))
    else $error("output item changed while stalled");

  // A taken byte keeps in_ready low while the decoder works on it.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted on consecutive cycles");

  // Black runs reported are never empty.
  a_run_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_BLACK_RUN) |-> run_length != 11'd0)
    else $error("empty black run reported");

  // Only black runs carry a start column and length.
  a_other_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind != KIND_BLACK_RUN) |-> (start_column == 11'd0) && (run_length == 11'd0))
    else $error("non-run item carries run fields");

endmodule

bind fax_g3_run_length_decoder fgr_checker u_fgr_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .kind         (kind),
  .start_column (start_column),
  .run_length   (run_length),
  .last         (last)
);

`default_nettype wire

// ===== tb/sv/fax_g3_run_length_decoder_checker.sv =====
// Scoreboard for the fax run-length decoder: predicts results per accepted item and compares.
`timescale 1ns / 1ps

module fax_g3_run_length_decoder_checker
  import fgr_pkg::*;
#(
  parameter int LINE_PIXELS = 1728
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic [7:0]  code_byte,
  input  wire logic        wr_en,
  input  wire logic        wr_index,
  input  wire logic [3:0]  wr_data,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic [1:0]  kind,
  input  wire logic [15:0] row_number,
  input  wire logic [10:0] start_column,
  input  wire logic [10:0] run_length,
  input  wire logic [10:0] widest_column,
  input  wire logic        last,
  output int               errors,
  output int               outstanding
);

  typedef struct {
    logic [1:0]  kind;
    logic [15:0] row;
    logic [10:0] start;
    logic [10:0] len;
    logic [10:0] widest;
    logic        last;
  } fax_event_t;

  fax_event_t  expected_events[$];
  fax_event_t  byte_events[$];

  // Decoder image: configuration and line state.
  logic        order_lsb;
  logic [3:0]  page_limit;
  logic [12:0] gathered;
  int          gathered_len;
  logic        black;
  int unsigned col;
  int unsigned widest;
  int unsigned row;
  int unsigned empty_lines;
  int unsigned last_empty;
  int          resync;
  int unsigned zeros;

  function automatic int unsigned page_limit_now();
    return (page_limit == 4'd0) ? 1 : page_limit;
  endfunction

  // Classify gathered bits: 1 exact code, 0 still a prefix, -1 no code.
  function automatic void match_code(input logic blk, input logic [12:0] bits,
                                     input int len, output int res, output int pels);
    code_entry_t e;
    logic        alive;
    res   = -1;
    pels  = 0;
    alive = (bits == 13'd0) && (len < 8);
    if (bits == 13'd0 && len == 8) begin
      res  = 1;
      pels = -1;
      return;
    end
    for (int k = 0; k < NUM_CODES; k++) begin
      e = blk ? BLACK_CODES[k] : WHITE_CODES[k];
      if (e.len >= len && (e.val >> (e.len - len)) == bits) begin
        if (e.len == len) begin
          res  = 1;
          pels = e.pels;
          return;
        end
        alive = 1'b1;
      end
    end
    res = alive ? 0 : -1;
  endfunction

  task automatic add_event(input logic [1:0] k, input int unsigned s, input int unsigned n);
    fax_event_t ev;
    ev.kind   = k;
    ev.row    = row[15:0];
    ev.start  = s[10:0];
    ev.len    = n[10:0];
    ev.widest = widest[10:0];
    ev.last   = 1'b0;
    byte_events.push_back(ev);
  endtask

  task automatic finish_line();
    black = 1'b0;
    if (col == 0) begin
      if (last_empty != row) begin
        if (empty_lines < 15) empty_lines++;
        last_empty = row;
        if (empty_lines >= page_limit_now()) add_event(KIND_PAGE_END, 0, 0);
      end
    end else begin
      if (col > widest) widest = col;
      add_event(KIND_ROW_END, 0, 0);
      if (row < 65535) row++;
      col         = 0;
      empty_lines = 0;
    end
  endtask

  task automatic apply_run(input int pels);
    int unsigned room;
    int unsigned n;
    room = (col < LINE_PIXELS) ? LINE_PIXELS - col : 0;
    n    = pels;
    if (n > room) n = room;
    if (black && n > 0) add_event(KIND_BLACK_RUN, col, n);
    col += n;
    if (n < 64) black = ~black;
  endtask

  task automatic decode_bit(input logic b);
    int res;
    int pels;
    if (empty_lines >= page_limit_now()) return;
    if (resync == 1) begin
      zeros = b ? 0 : ((zeros < 15) ? zeros + 1 : 15);
      if (zeros >= 6) begin
        resync = 2;
        zeros  = 0;
      end
      return;
    end
    if (resync == 2) begin
      if (b) begin
        resync = 0;
        finish_line();
      end
      return;
    end
    gathered = {gathered[11:0], b};
    gathered_len++;
    match_code(black, gathered, gathered_len, res, pels);
    if (res == 0 && gathered_len < MAX_CODE) return;
    gathered     = '0;
    gathered_len = 0;
    if (res == 1) begin
      if (pels < 0) resync = 2;
      else apply_run(pels);
    end else begin
      add_event(KIND_INVALID, 0, 0);
      resync = 1;
      zeros  = b ? 0 : 1;
    end
  endtask

  // Predict on input items, follow register writes, and compare output items.
  always @(posedge clk) begin
    if (rst) begin
      order_lsb    = 1'b0;
      page_limit   = 4'd10;
      gathered     = '0;
      gathered_len = 0;
      black        = 1'b0;
      col          = 0;
      widest       = 0;
      row          = 0;
      empty_lines  = 0;
      last_empty   = 0;
      resync       = 0;
      zeros        = 0;
      expected_events.delete();
    end else begin
      if (wr_en) begin
        if (wr_index == REG_LSB_FIRST) order_lsb = wr_data[0];
        else page_limit = wr_data;
      end
      if (in_valid && in_ready) begin
        byte_events.delete();
        for (int i = 0; i < 8; i++)
          decode_bit(order_lsb ? code_byte[i] : code_byte[7 - i]);
        if (byte_events.size() > 0) byte_events[byte_events.size() - 1].last = 1'b1;
        foreach (byte_events[i]) expected_events.push_back(byte_events[i]);
      end
      if (out_valid && out_ready) begin
        if (expected_events.size() == 0) begin
          $display("%0t: unexpected result kind=%0d row=%0d", $time, kind, row_number);
          errors++;
        end else begin
          fax_event_t ev;
          ev = expected_events.pop_front();
          if (kind !== ev.kind) begin
            $display("%0t: kind expected %0d actual %0d", $time, ev.kind, kind);
            errors++;
          end
          if (row_number !== ev.row) begin
            $display("%0t: row_number expected %0d actual %0d", $time, ev.row, row_number);
            errors++;
          end
          if (start_column !== ev.start) begin
            $display("%0t: start_column expected %0d actual %0d", $time, ev.start,
                     start_column);
            errors++;
          end
          if (run_length !== ev.len) begin
            $display("%0t: run_length expected %0d actual %0d", $time, ev.len, run_length);
            errors++;
          end
          if (widest_column !== ev.widest) begin
            $display("%0t: widest_column expected %0d actual %0d", $time, ev.widest,
                     widest_column);
            errors++;
          end
          if (last !== ev.last) begin
            $display("%0t: last expected %0d actual %0d", $time, ev.last, last);
            errors++;
          end
        end
      end
    end
    outstanding = expected_events.size();
  end

  initial begin
    errors      = 0;
    outstanding = 0;
  end

endmodule

// ===== tb/sv/fax_g3_run_length_decoder_tb.sv =====
// Top of the fax run-length decoder testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module fax_g3_run_length_decoder_tb;
  import fgr_pkg::*;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  code_byte;
  logic        wr_en;
  logic        wr_index;
  logic [3:0]  wr_data;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  kind;
  logic [15:0] row_number;
  logic [10:0] start_column;
  logic [10:0] run_length;
  logic [10:0] widest_column;
  logic        last;
  int          errors;
  int          outstanding;

  logic        bit_order_lsb;
  logic        quiet;
  logic        hold_request;
  logic        bitq[$];
  int          bytes_sent;

  fax_g3_run_length_decoder DUT (.*);

  fax_g3_run_length_decoder_checker checker_i (.*);

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Receiver: random back-pressure bursts, plus one long hold on request.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_request = 1'b0;
        out_ready <= 1'b1;
      end else if (!quiet && !rst && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    code_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  // Pack queued code bits into bytes in the decoder's current bit order.
  task automatic flush_bits();
    logic [7:0] b;
    while (bitq.size() >= 8) begin
      for (int i = 0; i < 8; i++)
        if (bit_order_lsb) b[i] = bitq.pop_front();
        else b[7 - i] = bitq.pop_front();
      send_byte(b);
    end
  endtask

  task automatic push_code(input code_entry_t e);
    for (int i = e.len - 1; i >= 0; i--) bitq.push_back(e.val[i]);
  endtask

  // End-of-line code with fill zeros so the closing one lands on a byte boundary.
  task automatic push_eol();
    repeat (8) bitq.push_back(1'b0);
    while ((bitq.size() + 1) % 8 != 0) bitq.push_back(1'b0);
    if ($urandom_range(0, 3) == 0) repeat (8) bitq.push_back(1'b0);
    bitq.push_back(1'b1);
  endtask

  // One coded line of random runs; color follows the short-run rule.
  task automatic push_line(input int runs);
    logic        blk;
    int          k;
    code_entry_t e;
    blk = 1'b0;
    for (int r = 0; r < runs; r++) begin
      k = ($urandom_range(0, 4) == 0) ? $urandom_range(64, NUM_CODES - 1)
                                      : $urandom_range(0, 63);
      e = blk ? BLACK_CODES[k] : WHITE_CODES[k];
      push_code(e);
      if (e.pels < 64) blk = ~blk;
    end
    push_eol();
  endtask

  task automatic random_traffic(input int count);
    int target;
    int pick;
    target = bytes_sent + count;
    while (bytes_sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        push_line($urandom_range(1, 10));
      end else if (pick < 78) begin
        push_eol();
      end else if (pick < 88) begin
        // Broken line: a code, random junk, then an end of line.
        push_code(WHITE_CODES[$urandom_range(0, NUM_CODES - 1)]);
        repeat ($urandom_range(1, 12)) bitq.push_back($urandom_range(0, 1));
        push_eol();
      end else begin
        repeat (8) bitq.push_back($urandom_range(0, 1));
        while (bitq.size() % 8 != 0) bitq.push_back($urandom_range(0, 1));
      end
      flush_bits();
    end
  endtask

  // Wait until the decoder is idle and every expected result has come out.
  task automatic wait_drained();
    @(posedge clk);
    while (outstanding != 0 || !in_ready) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [3:0] value);
    in_valid <= 1'b0;
    wait_drained();
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= value;
    @(posedge clk);
    wr_en <= 1'b0;
    @(posedge clk);
    if (idx == REG_LSB_FIRST) bit_order_lsb = value[0];
  endtask

  initial begin
    rst           = 1'b1;
    in_valid      = 1'b0;
    code_byte     = 8'h00;
    wr_en         = 1'b0;
    wr_index      = REG_LSB_FIRST;
    wr_data       = 4'd0;
    bit_order_lsb = 1'b0;
    quiet         = 1'b0;
    hold_request  = 1'b0;
    bytes_sent    = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: byte extremes, an empty line at row zero, longest runs.
    send_byte(8'h00);
    send_byte(8'h01);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'h80);
    send_byte(8'h7F);
    push_eol();
    // Clamped line: two 1728 makeups, then a short run flips to black.
    push_code(WHITE_CODES[90]);
    push_code(WHITE_CODES[90]);
    push_code(WHITE_CODES[0]);
    push_code(BLACK_CODES[2]);
    push_eol();
    // Black zero-length run, black makeup, terminating black.
    push_code(WHITE_CODES[5]);
    push_code(BLACK_CODES[0]);
    push_code(WHITE_CODES[3]);
    push_code(BLACK_CODES[NUM_CODES - 1]);
    push_code(BLACK_CODES[63]);
    push_eol();
    // Extended makeup is not in the set: seven zeros and a one is invalid.
    push_code(WHITE_CODES[2]);
    repeat (7) bitq.push_back(1'b0);
    bitq.push_back(1'b1);
    repeat (6) bitq.push_back(1'b0);
    while ((bitq.size() + 1) % 8 != 0) bitq.push_back(1'b0);
    bitq.push_back(1'b1);
    flush_bits();

    // Least significant bit first, largest page limit, with back-pressure.
    write_reg(REG_LSB_FIRST, 4'd1);
    write_reg(REG_EOL_LIMIT, 4'd15);
    random_traffic(40);
    hold_request = 1'b1;
    random_traffic(40);
    in_valid <= 1'b0;
    wait_drained();
    random_traffic(20);

    // Page end with the smallest limit, then bytes that must be ignored.
    write_reg(REG_LSB_FIRST, 4'd0);
    write_reg(REG_EOL_LIMIT, 4'd1);
    push_line(4);
    push_eol();
    flush_bits();
    random_traffic(10);
    write_reg(REG_EOL_LIMIT, 4'd15);
    random_traffic(70);

    // Last part at full rate.
    write_reg(REG_EOL_LIMIT, 4'd10);
    write_reg(REG_LSB_FIRST, 4'd1);
    quiet = 1'b1;
    random_traffic(70);
    in_valid <= 1'b0;

    wait_drained();
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("FAIL");
    $finish;
  end

endmodule
